[rtl/kpl_pkg.sv]
package kpl_pkg;

   localparam int unsigned DelayCfgBits = 16;
   localparam int unsigned CsrIndexBits = 3;

   typedef enum logic [1:0] {
      REQ_PIN  = 2'd0,
      REQ_TICK = 2'd1,
      REQ_TEST = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      MODE_MOMENTARY = 2'd0,
      MODE_TOGGLE    = 2'd1,
      MODE_LATCH     = 2'd2,
      MODE_INVALID   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      CAUSE_NONE   = 3'd0,
      CAUSE_PRESS  = 3'd1,
      CAUSE_TOGGLE = 3'd2,
      CAUSE_LATCH  = 3'd3,
      CAUSE_TEST   = 3'd4,
      CAUSE_AUTO   = 3'd5
   } cause_type;

   typedef enum logic [CsrIndexBits-1:0] {
      REG_PAD_ENABLE   = 3'd0,
      REG_PAD_MODE     = 3'd1,
      REG_LOCK_MASK    = 3'd2,
      REG_REARM_DELAY  = 3'd3,
      REG_ALERT_ENABLE = 3'd4,
      REG_ALERT_TARGET = 3'd5
   } reg_index_type;

   localparam logic [1:0] MaskBoth = 2'd3;

   typedef enum logic [1:0] {
      CHAN_BOTH = 2'd0,
      CHAN_ONE  = 2'd1,
      CHAN_TWO  = 2'd2
   } chan_type;

   typedef struct packed {
      logic                    pad_enable;
      mode_type                pad_mode;
      logic [1:0]              lock_mask;
      logic [DelayCfgBits-1:0] rearm_delay;
      logic                    alert_enable;
      logic [1:0]              alert_target_code;
   } cfg_type;

   typedef struct packed {
      logic prev_pressed;
      logic pressed_level;
      logic toggle_armed;
      logic rearm_expired;
   } flags_type;

   typedef struct packed {
      logic       lock_cmd_valid;
      logic       lock_arm;
      logic [1:0] lock_select;
      logic       alert_fire;
      logic [1:0] alert_channel;
      logic [1:0] alert_target_out;
      cause_type  action_cause;
      logic       pressed_now;
   } rsp_type;

   function automatic rsp_type issue(input cfg_type cfg, input logic arm,
                                     input cause_type cause, input logic with_alert);
      rsp_type r;
      r = '0;
      r.lock_cmd_valid = 1'b1;
      r.lock_arm       = arm;
      r.lock_select    = cfg.lock_mask;
      r.action_cause   = cause;
      if (with_alert && cfg.alert_enable) begin
         r.alert_fire       = 1'b1;
         r.alert_channel    = (cfg.lock_mask == MaskBoth) ? CHAN_BOTH :
                              (cfg.lock_mask[0] ? CHAN_ONE : CHAN_TWO);
         r.alert_target_out = cfg.alert_target_code;
      end
      return r;
   endfunction

endpackage

[rtl/kpl_step.sv]
module kpl_step #(
   parameter int unsigned DELAY_BITS = 16
) (
   input  kpl_pkg::cfg_type      cfg,
   input  kpl_pkg::flags_type    flags,
   input  logic [DELAY_BITS-1:0] count,
   input  logic [1:0]            req_type,
   input  logic                  pin_level,
   output kpl_pkg::flags_type    flags_next,
   output logic [DELAY_BITS-1:0] count_next,
   output kpl_pkg::rsp_type      rsp
);
   import kpl_pkg::*;

   localparam int unsigned CmpBits = (DELAY_BITS > DelayCfgBits) ? DELAY_BITS : DelayCfgBits;

   logic rise;
   logic level;
   logic at_delay;

   assign level    = ~pin_level;
   assign rise     = level & ~flags.prev_pressed;
   assign at_delay = CmpBits'(count) >= CmpBits'(cfg.rearm_delay);

   always_comb begin
      flags_next = flags;
      count_next = count;
      rsp        = '0;
      case (req_type)
         REQ_PIN: begin
            flags_next.pressed_level = level;
            flags_next.prev_pressed  = level;
            if (cfg.pad_enable) begin
               if (cfg.pad_mode == MODE_LATCH && level != flags.prev_pressed) begin
                  rsp = issue(cfg, level, CAUSE_LATCH, 1'b1);
                  flags_next.rearm_expired = 1'b1;
               end else if (cfg.pad_mode == MODE_TOGGLE && rise) begin
                  flags_next.toggle_armed  = ~flags.toggle_armed;
                  rsp = issue(cfg, ~flags.toggle_armed, CAUSE_TOGGLE, 1'b1);
                  flags_next.rearm_expired = 1'b1;
               end else if (cfg.pad_mode == MODE_MOMENTARY && rise) begin
                  rsp = issue(cfg, 1'b0, CAUSE_PRESS, 1'b1);
                  flags_next.rearm_expired = 1'b0;
                  count_next = '0;
               end
            end
         end
         REQ_TICK: begin
            if (at_delay && !flags.rearm_expired) begin
               rsp = issue(cfg, 1'b1, CAUSE_AUTO, 1'b0);
               flags_next.rearm_expired = 1'b1;
            end else if (count != '1) begin
               count_next = count + 1'b1;
            end
         end
         REQ_TEST: begin
            if (cfg.pad_mode == MODE_LATCH) begin
               rsp = issue(cfg, 1'b1, CAUSE_TEST, 1'b1);
               flags_next.rearm_expired = 1'b1;
            end else if (cfg.pad_mode == MODE_TOGGLE) begin
               flags_next.toggle_armed  = ~flags.toggle_armed;
               rsp = issue(cfg, ~flags.toggle_armed, CAUSE_TEST, 1'b1);
               flags_next.rearm_expired = 1'b1;
            end else begin
               rsp = issue(cfg, 1'b0, CAUSE_TEST, 1'b1);
               flags_next.rearm_expired = 1'b0;
               count_next = '0;
            end
         end
         default: begin
         end
      endcase
      rsp.pressed_now = flags_next.pressed_level;
   end

endmodule

[rtl/keypad_lock_input_controller.sv]
// Keypad lock input controller: one active-low keypad pin driving up to two locks.
// Request channel (req_*): one transfer per pin sample, tick or test
// command. Every request yields exactly one result transfer on the rsp_* channel,
// carrying any lock command, alert and the current pressed state.
// Latency: the result is valid the cycle after the request transfer.
// Throughput: one request per cycle; the result register sits between the two
// channels, so req_ready stays high while rsp_ready is high or the result register
// is empty. When the receiver stalls, the result is held and req_ready drops until
// it is taken.
// Configuration (csr_*): index selects pad_enable, pad_mode, lock_mask,
// rearm_delay, alert_enable or alert_target_code; csr_ready is always high and
// writes to unknown indexes are dropped. Write only while idle.
// Reset (synchronous): registers return to 1, momentary, lock one, 4 ticks,
// alerts on, target 3; keypad state and the re-arm count clear, leaving the
// re-arm timer running. DELAY_BITS sets the saturating tick counter width.
module keypad_lock_input_controller #(
   parameter int unsigned DELAY_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_type,
   input  logic                                req_pin_level,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_lock_cmd_valid,
   output logic                                rsp_lock_arm,
   output logic [1:0]                          rsp_lock_select,
   output logic                                rsp_alert_fire,
   output logic [1:0]                          rsp_alert_channel,
   output logic [1:0]                          rsp_alert_target_out,
   output logic [2:0]                          rsp_action_cause,
   output logic                                rsp_pressed_now,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kpl_pkg::CsrIndexBits-1:0]    csr_index,
   input  logic [kpl_pkg::DelayCfgBits-1:0]    csr_data
);
   import kpl_pkg::*;

   cfg_type               cfg_ff, cfg_in;
   flags_type             flags_ff, flags_in, flags_step;
   logic [DELAY_BITS-1:0] count_ff, count_in, count_step;
   rsp_type               rsp_ff, rsp_in, rsp_step;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  req_fire;
   logic                  csr_fire;
   mode_type              mode_wr;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_fire  = req_valid & req_ready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid;

   kpl_step #(
      .DELAY_BITS(DELAY_BITS)
   ) u_step (
      .cfg        (cfg_ff),
      .flags      (flags_ff),
      .count      (count_ff),
      .req_type   (req_type),
      .pin_level  (req_pin_level),
      .flags_next (flags_step),
      .count_next (count_step),
      .rsp        (rsp_step)
   );

   always_comb begin
      mode_wr = mode_type'(csr_data[1:0]);
      if (mode_wr == MODE_INVALID) begin
         mode_wr = (cfg_ff.pad_mode == MODE_LATCH) ? MODE_LATCH : MODE_MOMENTARY;
      end
   end

   always_comb begin
      cfg_in       = cfg_ff;
      flags_in     = flags_ff;
      count_in     = count_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (req_fire) begin
         flags_in     = flags_step;
         count_in     = count_step;
         rsp_in       = rsp_step;
         rsp_valid_in = 1'b1;
      end
      if (csr_fire) begin
         case (csr_index)
            REG_PAD_ENABLE:   cfg_in.pad_enable = csr_data[0];
            REG_PAD_MODE: begin
               cfg_in.pad_mode = mode_wr;
               if (mode_wr != MODE_TOGGLE) begin
                  flags_in.toggle_armed = 1'b0;
               end
            end
            REG_LOCK_MASK: begin
               if (csr_data[1:0] != 2'd0) begin
                  cfg_in.lock_mask = csr_data[1:0];
               end
            end
            REG_REARM_DELAY:  cfg_in.rearm_delay = csr_data;
            REG_ALERT_ENABLE: cfg_in.alert_enable = csr_data[0];
            REG_ALERT_TARGET: cfg_in.alert_target_code = csr_data[1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pad_enable        <= 1'b1;
         cfg_ff.pad_mode          <= MODE_MOMENTARY;
         cfg_ff.lock_mask         <= 2'd1;
         cfg_ff.rearm_delay       <= DelayCfgBits'(4);
         cfg_ff.alert_enable      <= 1'b1;
         cfg_ff.alert_target_code <= 2'd3;
         flags_ff                 <= '0;
         count_ff                 <= '0;
         rsp_valid_ff             <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         flags_ff     <= flags_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_lock_cmd_valid   = rsp_ff.lock_cmd_valid;
   assign rsp_lock_arm         = rsp_ff.lock_arm;
   assign rsp_lock_select      = rsp_ff.lock_select;
   assign rsp_alert_fire       = rsp_ff.alert_fire;
   assign rsp_alert_channel    = rsp_ff.alert_channel;
   assign rsp_alert_target_out = rsp_ff.alert_target_out;
   assign rsp_action_cause     = rsp_ff.action_cause;
   assign rsp_pressed_now      = rsp_ff.pressed_now;

endmodule

[verif/keypad_lock_input_controller_tb.sv]
module keypad_lock_input_controller_tb;
   import kpl_pkg::*;

   localparam int unsigned DelayBits = 16;
   localparam logic [1:0] ReqUnknown = 2'd3;
   localparam logic [CsrIndexBits-1:0] RegSpareLo = 3'd6;
   localparam logic [CsrIndexBits-1:0] RegSpareHi = 3'd7;

   typedef struct packed {
      logic [1:0] kind;
      logic       pin;
   } pad_event_type;

   logic                    clock;
   logic                    reset;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [1:0]              req_type = REQ_PIN;
   logic                    req_pin_level = 1'b1;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic                    rsp_lock_cmd_valid;
   logic                    rsp_lock_arm;
   logic [1:0]              rsp_lock_select;
   logic                    rsp_alert_fire;
   logic [1:0]              rsp_alert_channel;
   logic [1:0]              rsp_alert_target_out;
   logic [2:0]              rsp_action_cause;
   logic                    rsp_pressed_now;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CsrIndexBits-1:0] csr_index;
   logic [DelayCfgBits-1:0] csr_data;

   // mirror of the keypad channel
   cfg_type              pad_cfg;
   logic                 was_pressed;
   logic                 now_pressed;
   logic                 toggle_state;
   logic                 rearm_done;
   logic [DelayBits-1:0] tick_count;

   pad_event_type keypad_events[$];
   rsp_type       results_due[$];
   pad_event_type next_event;
   rsp_type       oldest_due;

   int   n_queued;
   int   n_accepted;
   int   n_errors;
   int   tx_gap;
   int   rx_gap;
   bit   tx_idle_on;
   bit   rx_idle_on;
   bit   hold_go;
   logic rx_hold;

   keypad_lock_input_controller #(.DELAY_BITS(DelayBits)) dut (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic rsp_type lock_action(input logic arm, input cause_type why,
                                           input logic alerted);
      rsp_type r;
      r = '0;
      r.lock_cmd_valid = 1'b1;
      r.lock_arm       = arm;
      r.lock_select    = pad_cfg.lock_mask;
      r.action_cause   = why;
      if (alerted && pad_cfg.alert_enable) begin
         r.alert_fire       = 1'b1;
         r.alert_channel    = (pad_cfg.lock_mask == MaskBoth) ? CHAN_BOTH :
                              (pad_cfg.lock_mask[0] ? CHAN_ONE : CHAN_TWO);
         r.alert_target_out = pad_cfg.alert_target_code;
      end
      return r;
   endfunction

   function automatic rsp_type keypad_step(input logic [1:0] kind, input logic pin);
      rsp_type r;
      logic    rise;
      r = '0;
      case (kind)
         REQ_PIN: begin
            now_pressed = ~pin;
            rise = now_pressed && !was_pressed;
            if (pad_cfg.pad_enable) begin
               if (pad_cfg.pad_mode == MODE_LATCH && now_pressed != was_pressed) begin
                  r = lock_action(now_pressed, CAUSE_LATCH, 1'b1);
                  rearm_done = 1'b1;
               end else if (pad_cfg.pad_mode == MODE_TOGGLE && rise) begin
                  toggle_state = ~toggle_state;
                  r = lock_action(toggle_state, CAUSE_TOGGLE, 1'b1);
                  rearm_done = 1'b1;
               end else if (pad_cfg.pad_mode == MODE_MOMENTARY && rise) begin
                  r = lock_action(1'b0, CAUSE_PRESS, 1'b1);
                  rearm_done = 1'b0;
                  tick_count = '0;
               end
            end
            was_pressed = now_pressed;
         end
         REQ_TICK: begin
            if (tick_count >= pad_cfg.rearm_delay && !rearm_done) begin
               r = lock_action(1'b1, CAUSE_AUTO, 1'b0);
               rearm_done = 1'b1;
            end else if (tick_count != '1) begin
               tick_count = tick_count + 1'b1;
            end
         end
         REQ_TEST: begin
            if (pad_cfg.pad_mode == MODE_LATCH) begin
               r = lock_action(1'b1, CAUSE_TEST, 1'b1);
               rearm_done = 1'b1;
            end else if (pad_cfg.pad_mode == MODE_TOGGLE) begin
               toggle_state = ~toggle_state;
               r = lock_action(toggle_state, CAUSE_TEST, 1'b1);
               rearm_done = 1'b1;
            end else begin
               r = lock_action(1'b0, CAUSE_TEST, 1'b1);
               rearm_done = 1'b0;
               tick_count = '0;
            end
         end
         default: ;
      endcase
      r.pressed_now = now_pressed;
      return r;
   endfunction

   function automatic void apply_csr(input logic [CsrIndexBits-1:0] idx,
                                     input logic [DelayCfgBits-1:0] val);
      mode_type m;
      case (idx)
         REG_PAD_ENABLE: pad_cfg.pad_enable = val[0];
         REG_PAD_MODE: begin
            m = mode_type'(val[1:0]);
            if (m == MODE_INVALID)
               m = (pad_cfg.pad_mode == MODE_LATCH) ? MODE_LATCH : MODE_MOMENTARY;
            if (m != MODE_TOGGLE)
               toggle_state = 1'b0;
            pad_cfg.pad_mode = m;
         end
         REG_LOCK_MASK: begin
            if (val[1:0] != 2'd0)
               pad_cfg.lock_mask = val[1:0];
         end
         REG_REARM_DELAY: pad_cfg.rearm_delay = val;
         REG_ALERT_ENABLE: pad_cfg.alert_enable = val[0];
         REG_ALERT_TARGET: pad_cfg.alert_target_code = val[1:0];
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string what, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
         n_errors++;
      end
   endfunction

   // request driver; also tracks register writes and each transfer's outcome
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         pad_cfg.pad_enable        = 1'b1;
         pad_cfg.pad_mode          = MODE_MOMENTARY;
         pad_cfg.lock_mask         = 2'd1;
         pad_cfg.rearm_delay       = 16'd4;
         pad_cfg.alert_enable      = 1'b1;
         pad_cfg.alert_target_code = 2'd3;
         was_pressed  = 1'b0;
         now_pressed  = 1'b0;
         toggle_state = 1'b0;
         rearm_done   = 1'b0;
         tick_count   = '0;
      end else begin
         if (req_valid && req_ready) begin
            results_due.push_back(keypad_step(req_type, req_pin_level));
            n_accepted++;
         end
         if (csr_valid && csr_ready)
            apply_csr(csr_index, csr_data);
         if (!req_valid || req_ready) begin
            if (tx_gap != 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else if (tx_idle_on && $urandom_range(0, 7) == 0) begin
               tx_gap = $urandom_range(0, 17);
               req_valid <= 1'b0;
            end else if (keypad_events.size() != 0) begin
               next_event = keypad_events.pop_front();
               req_valid     <= 1'b1;
               req_type      <= next_event.kind;
               req_pin_level <= next_event.pin;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               $display("%0t: stray result, expected none, got cause %0d pressed %0d",
                        $time, rsp_action_cause, rsp_pressed_now);
               n_errors++;
            end else begin
               oldest_due = results_due.pop_front();
               check_field("lock_cmd_valid", 32'(oldest_due.lock_cmd_valid),
                           32'(rsp_lock_cmd_valid));
               check_field("lock_arm", 32'(oldest_due.lock_arm), 32'(rsp_lock_arm));
               check_field("lock_select", 32'(oldest_due.lock_select),
                           32'(rsp_lock_select));
               check_field("alert_fire", 32'(oldest_due.alert_fire), 32'(rsp_alert_fire));
               check_field("alert_channel", 32'(oldest_due.alert_channel),
                           32'(rsp_alert_channel));
               check_field("alert_target_out", 32'(oldest_due.alert_target_out),
                           32'(rsp_alert_target_out));
               check_field("action_cause", 32'(oldest_due.action_cause),
                           32'(rsp_action_cause));
               check_field("pressed_now", 32'(oldest_due.pressed_now),
                           32'(rsp_pressed_now));
            end
         end
         if (rx_hold) begin
            rsp_ready <= 1'b0;
         end else if (rx_gap != 0) begin
            rx_gap--;
            rsp_ready <= 1'b0;
         end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(0, 17);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // long receiver hold so the result register fills and the input backs up
   initial begin
      rx_hold = 1'b0;
      wait (hold_go);
      @(posedge clock);
      rx_hold <= 1'b1;
      repeat (100) @(posedge clock);
      rx_hold <= 1'b0;
   end

   initial begin
      #6_000_000;
      $display("keypad_lock_input_controller_tb: done, errors");
      $finish;
   end

   task automatic post(input logic [1:0] kind, input logic pin);
      keypad_events.push_back(pad_event_type'{kind, pin});
      n_queued++;
   endtask

   task automatic settle();
      while (n_accepted != n_queued || results_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexBits-1:0] idx,
                            input logic [DelayCfgBits-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic random_burst(input int count);
      int unsigned pick;
      logic        lvl;
      lvl = 1'($urandom_range(0, 1));
      repeat (count) begin
         pick = $urandom_range(0, 19);
         if (pick < 9) begin
            if ($urandom_range(0, 3) != 0)
               lvl = ~lvl;
            post(REQ_PIN, lvl);
         end else if (pick < 16) begin
            post(REQ_TICK, 1'($urandom_range(0, 1)));
         end else if (pick < 19) begin
            post(REQ_TEST, 1'($urandom_range(0, 1)));
         end else begin
            post(ReqUnknown, 1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic random_setup();
      logic [DelayCfgBits-1:0] delay;
      logic [DelayCfgBits-1:0] enable_word;
      case ($urandom_range(0, 9))
         0: delay = '0;
         1: delay = '1;
         2: delay = DelayCfgBits'($urandom);
         default: delay = DelayCfgBits'($urandom_range(0, 8));
      endcase
      enable_word = DelayCfgBits'($urandom);
      if ($urandom_range(0, 3) != 0)
         enable_word[0] = 1'b1;
      write_reg(REG_PAD_ENABLE, enable_word);
      write_reg(REG_PAD_MODE, DelayCfgBits'($urandom));
      write_reg(REG_LOCK_MASK, DelayCfgBits'($urandom));
      write_reg(REG_REARM_DELAY, delay);
      write_reg(REG_ALERT_ENABLE, DelayCfgBits'($urandom));
      write_reg(REG_ALERT_TARGET, DelayCfgBits'($urandom));
      if ($urandom_range(0, 3) == 0)
         write_reg($urandom_range(0, 1) ? RegSpareHi : RegSpareLo,
                   DelayCfgBits'($urandom));
   endtask

   initial begin
      reset     = 1'b1;
      csr_valid = 1'b0;
      csr_index = REG_PAD_ENABLE;
      csr_data  = '0;
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset values: timer runs and re-arms on the fifth tick
      repeat (5) post(REQ_TICK, 1'b1);
      post(REQ_PIN, 1'b0);
      post(REQ_PIN, 1'b0);
      post(REQ_PIN, 1'b1);
      post(REQ_TEST, 1'b0);
      post(ReqUnknown, 1'b0);
      settle();

      write_reg(REG_PAD_MODE, DelayCfgBits'(MODE_TOGGLE));
      write_reg(REG_LOCK_MASK, DelayCfgBits'(MaskBoth));
      write_reg(REG_ALERT_TARGET, 16'd0);
      post(REQ_PIN, 1'b0);
      post(REQ_PIN, 1'b1);
      post(REQ_PIN, 1'b0);
      post(REQ_TEST, 1'b1);
      post(REQ_TICK, 1'b0);
      settle();

      write_reg(REG_PAD_MODE, DelayCfgBits'(MODE_LATCH));
      write_reg(REG_LOCK_MASK, 16'd2);
      write_reg(REG_ALERT_ENABLE, 16'd0);
      post(REQ_PIN, 1'b1);
      post(REQ_PIN, 1'b0);
      post(REQ_TEST, 1'b0);
      settle();
      // invalid mode keeps latch
      write_reg(REG_PAD_MODE, DelayCfgBits'(MODE_INVALID));
      post(REQ_PIN, 1'b1);
      settle();

      write_reg(REG_PAD_MODE, DelayCfgBits'(MODE_TOGGLE));
      write_reg(REG_ALERT_ENABLE, 16'hFFFF);
      post(REQ_PIN, 1'b0);
      settle();
      // invalid mode from toggle drops to momentary and clears the toggle bit
      write_reg(REG_PAD_MODE, DelayCfgBits'(MODE_INVALID));
      write_reg(REG_PAD_MODE, DelayCfgBits'(MODE_TOGGLE));
      post(REQ_PIN, 1'b1);
      post(REQ_PIN, 1'b0);
      settle();

      write_reg(REG_PAD_ENABLE, 16'hFFFE);
      write_reg(REG_PAD_MODE, DelayCfgBits'(MODE_MOMENTARY));
      write_reg(REG_LOCK_MASK, 16'd1);
      post(REQ_PIN, 1'b1);
      post(REQ_PIN, 1'b0);
      post(REQ_TEST, 1'b1);
      settle();
      write_reg(REG_PAD_ENABLE, 16'd1);
      post(REQ_PIN, 1'b0);
      post(REQ_PIN, 1'b1);
      settle();

      // zero mask is dropped, spare indexes are dropped
      write_reg(REG_LOCK_MASK, 16'd0);
      write_reg(RegSpareLo, 16'hFFFF);
      write_reg(RegSpareHi, 16'h5A5A);
      write_reg(REG_ALERT_TARGET, 16'd1);
      write_reg(REG_REARM_DELAY, 16'd0);
      post(REQ_PIN, 1'b0);
      post(REQ_TICK, 1'b1);
      settle();

      // longer delay: auto re-arm only once the count reaches it
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      write_reg(REG_REARM_DELAY, 16'd12);
      post(REQ_PIN, 1'b1);
      post(REQ_PIN, 1'b0);
      repeat (15) post(REQ_TICK, 1'b1);
      settle();

      // receiver holds off while the sender keeps offering
      write_reg(REG_REARM_DELAY, 16'd2);
      hold_go = 1'b1;
      random_burst(40);
      settle();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;

      for (int seg = 0; seg < 6; seg++) begin
         if (seg == 5) begin
            tx_idle_on = 1'b0;
            rx_idle_on = 1'b0;
         end
         random_setup();
         random_burst(60);
         settle();
      end

      repeat (4) @(posedge clock);
      if (n_errors == 0)
         $display("keypad_lock_input_controller_tb: done, clean");
      else
         $display("keypad_lock_input_controller_tb: done, errors");
      $finish;
   end

endmodule
